// ===== src/mmac_pkg.sv =====
// Shared sizes, widths, register codes and the cell command struct
// for the matrix multiply-accumulate core. No dependencies.
`default_nettype none

package mmac_pkg;

    // Array sizes
    localparam int MAX_INNER  = 64;
    localparam int MAX_COLS   = 32;
    localparam int DATA_W     = 16;

    // Derived widths, and the fixed accumulator width
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = 39;
    localparam int ROW_W      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int POS_W      = $clog2(MAX_INNER + 1);
    localparam int NC_W       = $clog2(MAX_COLS + 1);

    // Fixed field widths and the compare width
    localparam int WROW_W     = 6;
    localparam int WCOL_W     = 5;
    localparam int INNER_W    = 7;
    localparam int OCOLS_W    = 6;
    localparam int CMP_W      = (INNER_W > POS_W) ? INNER_W : POS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 1'b1;

    // Input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_FEED = 1'b1;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     feed;
        logic [ROW_W-1:0]         rd_addr;
        logic [ROW_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] value;
        logic                     shift;
        logic                     clear;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/mmac_cell.sv =====
// One output column: its slice of the weight store, a multiplier and an
// accumulator that shifts toward column zero on drain. Depends on mmac_pkg.
`default_nettype none

module mmac_cell
    import mmac_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cell_cmd_t               cmd,
    input  wire logic                    wr_en,
    input  wire logic signed [SUM_W-1:0] acc_in,
    output logic signed [SUM_W-1:0]      acc_out
);

    logic signed [DATA_W-1:0] mem [MAX_INNER];

    logic signed [DATA_W-1:0] w_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic                     v1_reg;
    logic                     v2_reg;

    // Weight column memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.value;
        end
        if (cmd.feed)
        begin
            w_reg <= mem[cmd.rd_addr];
            x_reg <= cmd.value;
        end
        prod_reg <= x_reg * w_reg;
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (cmd.shift)
        begin
            acc_next = acc_in;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg  <= cmd.feed;
            v2_reg  <= v1_reg;
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

`default_nettype wire

// ===== src/matrix_multiply_accumulate_core.sv =====
// Top level: sequencer, configuration registers and the row of column cells.
// Depends on mmac_pkg and mmac_cell.
//
//   Channel   Signals                                          Direction
//   -------   ----------------------------------------------   ---------
//   config    cfg_write, cfg_index, cfg_data                   in
//   command   start/busy, action, weight_row, weight_col,      in
//             value, last_element, last_row
//   result    result_valid, column, sum, row_done, matrix_done out
//
// Loads and feeds that do not end a row are taken one per cycle; each feed
// runs a three-stage path in every cell (weight read, multiply, accumulate).
// A feed that ends a row holds busy while the multiply path settles in the
// flush state, then while the accumulator chain shifts one column out per
// cycle, column 0 first, for n = min(out_cols, 32) columns. Reset clears the
// accumulators at once; the weight store is not cleared. Results cannot be
// stalled.
`default_nettype none

module matrix_multiply_accumulate_core
    import mmac_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     action,
    input  wire logic [WROW_W-1:0]        weight_row,
    input  wire logic [WCOL_W-1:0]        weight_col,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     last_element,
    input  wire logic                     last_row,
    output logic                          result_valid,
    output logic [WCOL_W-1:0]             column,
    output logic signed [SUM_W-1:0]       sum,
    output logic                          row_done,
    output logic                          matrix_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    state_t                state_reg;
    logic                  flush_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  mdone_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [INNER_W-1:0]    inner_size_reg;
    logic [OCOLS_W-1:0]    out_cols_reg;

    logic                  accept;
    logic                  is_feed;
    logic                  is_load;
    logic                  load_ok;
    logic                  feed_use;
    logic [CMP_W-1:0]      limit;
    logic [NC_W-1:0]       ncols;
    logic                  col_last;
    cell_cmd_t             cmd;
    logic [MAX_COLS-1:0]   wr_en;
    logic signed [SUM_W-1:0] chain [MAX_COLS + 1];

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_feed  = accept && (action == ACT_FEED);
    assign is_load  = accept && (action == ACT_LOAD);
    assign load_ok  = is_load && (int'(weight_row) < MAX_INNER)
                      && (int'(weight_col) < MAX_COLS);

    assign limit    = (int'(inner_size_reg) > MAX_INNER) ? CMP_W'(MAX_INNER)
                                                         : CMP_W'(inner_size_reg);
    assign feed_use = is_feed && (CMP_W'(pos_reg) < limit);

    assign ncols    = (int'(out_cols_reg) > MAX_COLS) ? NC_W'(MAX_COLS)
                                                      : NC_W'(out_cols_reg);
    assign col_last = (NC_W'(col_reg) + NC_W'(1)) == ncols;

    always_comb
    begin
        cmd.feed    = feed_use;
        cmd.rd_addr = pos_reg[ROW_W-1:0];
        cmd.wr_addr = ROW_W'(weight_row);
        cmd.value   = value;
        cmd.shift   = (state_reg == ST_DRAIN) && !col_last;
        // drop the leftover columns at the end of the drain, or in flush when no columns drain
        cmd.clear   = ((state_reg == ST_DRAIN) && col_last)
                      || ((state_reg == ST_FLUSH) && flush_reg && (ncols == '0));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_size_reg <= INNER_W'(8);
            out_cols_reg   <= OCOLS_W'(32);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INNER_SIZE: inner_size_reg <= cfg_data[INNER_W-1:0];
                REG_OUT_COLS:   out_cols_reg   <= cfg_data[OCOLS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
            col_reg   <= '0;
            mdone_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (is_feed && last_element)
                    begin
                        pos_reg   <= '0;
                        mdone_reg <= last_row;
                        flush_reg <= 1'b0;
                        col_reg   <= '0;
                        state_reg <= ST_FLUSH;
                    end
                    else if (feed_use)
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                ST_FLUSH:
                begin
                    flush_reg <= 1'b1;
                    if (flush_reg)
                    begin
                        state_reg <= (ncols == '0) ? ST_IDLE : ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    col_reg <= col_reg + COL_W'(1);
                    if (col_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Row of column cells, chained toward column zero
    assign chain[MAX_COLS] = '0;

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_cell
        assign wr_en[c] = load_ok && (int'(weight_col) == c);

        mmac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .wr_en   (wr_en[c]),
            .acc_in  (chain[c + 1]),
            .acc_out (chain[c])
        );
    end

    assign result_valid = (state_reg == ST_DRAIN);
    assign column       = WCOL_W'(col_reg);
    assign sum          = chain[0];
    assign row_done     = col_last;
    assign matrix_done  = mdone_reg;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_accumulate_core: weight loads and row feeds
// go through a queued driver, and the column sums are checked against an in-bench predictor.
// Depends on mmac_pkg and the core RTL only.

module tb;
    import mmac_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED   = 40;
    // Shared-dimension rows that random rows may reach; keeps the weight loads few
    localparam int FILL_CAP      = 3;

    typedef struct {
        logic                     act;
        logic [WROW_W-1:0]        wrow;
        logic [WCOL_W-1:0]        wcol;
        logic signed [DATA_W-1:0] val;
        logic                     end_row;
        logic                     end_mat;
    } mac_op_t;

    typedef struct {
        logic [WCOL_W-1:0]       col;
        logic signed [SUM_W-1:0] total;
        logic                    rdone;
        logic                    mdone;
    } col_sum_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index    = REG_INNER_SIZE;
    logic [CFG_DATA_W-1:0]    cfg_data     = '0;
    logic                     start        = 1'b0;
    logic                     action       = ACT_LOAD;
    logic [WROW_W-1:0]        weight_row   = '0;
    logic [WCOL_W-1:0]        weight_col   = '0;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     last_element = 1'b0;
    logic                     last_row     = 1'b0;
    logic                     busy;
    logic                     result_valid;
    logic [WCOL_W-1:0]        column;
    logic signed [SUM_W-1:0]  sum;
    logic                     row_done;
    logic                     matrix_done;

    matrix_multiply_accumulate_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .weight_row   (weight_row),
        .weight_col   (weight_col),
        .value        (value),
        .last_element (last_element),
        .last_row     (last_row),
        .result_valid (result_valid),
        .column       (column),
        .sum          (sum),
        .row_done     (row_done),
        .matrix_done  (matrix_done)
    );

    always #2 clk = ~clk;

    mac_op_t  ops_q[$];
    col_sum_t sums_q[$];
    mac_op_t  cur_op;
    bit       holding  = 1'b0;
    int       idle_pct = 0;
    int       errs     = 0;

    // Predictor copy of the block state and registers
    logic signed [DATA_W-1:0] wts [MAX_INNER][MAX_COLS];
    logic signed [SUM_W-1:0]  acc [MAX_COLS] = '{default: '0};
    int                       row_pos   = 0;
    int                       inner_reg = 8;
    int                       ocols_reg = 32;

    // Entries queued for loading so far; feeds never read anything else
    bit loaded [MAX_INNER][MAX_COLS] = '{default: 1'b0};

    function automatic int inner_limit();
        return (inner_reg < MAX_INNER) ? inner_reg : MAX_INNER;
    endfunction

    task automatic note_error(input string msg);
        errs++;
        if (errs <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic apply_op(input mac_op_t op);
        int       n;
        longint   prod;
        col_sum_t r;
        if (op.act == ACT_LOAD)
        begin
            wts[op.wrow][op.wcol] = op.val;
            return;
        end
        // Elements past the inner size add nothing and leave the position saturated
        if (row_pos < inner_limit())
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                prod   = longint'(op.val) * longint'(wts[row_pos][c]);
                acc[c] = acc[c] + prod[SUM_W-1:0];
            end
            row_pos++;
        end
        if (!op.end_row)
            return;
        n = (ocols_reg < MAX_COLS) ? ocols_reg : MAX_COLS;
        for (int c = 0; c < n; c++)
        begin
            r.col   = WCOL_W'(c);
            r.total = acc[c];
            r.rdone = (c == n - 1);
            r.mdone = op.end_mat;
            sums_q.push_back(r);
        end
        for (int c = 0; c < MAX_COLS; c++)
            acc[c] = '0;
        row_pos = 0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'sh0100;
            4:       return 16'shFF00;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic push_load(input int r, input int c, input logic signed [DATA_W-1:0] v,
                             input logic le, input logic lr);
        mac_op_t op;
        op.act     = ACT_LOAD;
        op.wrow    = WROW_W'(r);
        op.wcol    = WCOL_W'(c);
        op.val     = v;
        op.end_row = le;
        op.end_mat = lr;
        ops_q.push_back(op);
        loaded[r][c] = 1'b1;
    endtask

    task automatic push_feed(input logic signed [DATA_W-1:0] v, input logic le,
                             input logic lr);
        mac_op_t op;
        op.act     = ACT_FEED;
        op.wrow    = WROW_W'($urandom);
        op.wcol    = WCOL_W'($urandom);
        op.val     = v;
        op.end_row = le;
        op.end_mat = lr;
        ops_q.push_back(op);
    endtask

    task automatic push_noise();
        push_load($urandom_range(0, MAX_INNER - 1), $urandom_range(0, MAX_COLS - 1),
                  pick_value(), 1'($urandom), 1'($urandom));
    endtask

    // Load every missing weight of the first k shared-dimension rows
    task automatic fill_rows(input int k);
        for (int r = 0; r < k; r++)
            for (int c = 0; c < MAX_COLS; c++)
                if (!loaded[r][c])
                    push_load(r, c, pick_value(), 1'($urandom), 1'($urandom));
    endtask

    task automatic push_row(input int len, input logic lr, input bit noisy);
        fill_rows((len < inner_limit()) ? len : inner_limit());
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_noise();
            push_feed(pick_value(), i == len - 1, (i == len - 1) ? lr : 1'($urandom));
        end
    endtask

    task automatic random_phase(input int n_items);
        int cnt;
        int len;
        int lim;
        cnt = 0;
        while (cnt < n_items)
        begin
            lim = inner_limit();
            if ($urandom_range(0, 9) < 2)
            begin
                push_noise();
                cnt++;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       len = (lim < FILL_CAP) ? lim + $urandom_range(1, 3) : FILL_CAP;
                    1:       len = 1;
                    default: len = $urandom_range(1, (lim > FILL_CAP) ? FILL_CAP
                                                  : ((lim > 0) ? lim : 4));
                endcase
                push_row(len, 1'($urandom), 1'b1);
                cnt += len;
            end
        end
    endtask

    // Hold until every queued transfer is taken and every sum has come out
    task automatic settle();
        while (ops_q.size() != 0 || holding || sums_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_INNER_SIZE)
            inner_reg = data & 'h7F;
        else
            ocols_reg = data & 'h3F;
    endtask

    task automatic run_phase(input int inner, input int ocols, input int idle, input int n);
        settle();
        set_reg(REG_INNER_SIZE, inner);
        set_reg(REG_OUT_COLS, ocols);
        idle_pct = idle;
        random_phase(n);
    endtask

    // Driver: present the next operation at the falling edge, hold it until taken
    always @(negedge clk)
    begin
        if (rst_n && !holding && ops_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
        begin
            cur_op = ops_q.pop_front();
            holding = 1'b1;
            start        <= 1'b1;
            action       <= cur_op.act;
            weight_row   <= cur_op.wrow;
            weight_col   <= cur_op.wcol;
            value        <= cur_op.val;
            last_element <= cur_op.end_row;
            last_row     <= cur_op.end_mat;
        end
        else if (!holding)
        begin
            start <= 1'b0;
        end
    end

    // Transfer happens on start with busy low
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            apply_op(cur_op);
            holding = 1'b0;
        end
    end

    // Monitor: compare each strobed result with the oldest expected sum
    always @(posedge clk)
    begin
        col_sum_t want;
        if (rst_n && result_valid)
        begin
            if (sums_q.size() == 0)
            begin
                note_error($sformatf("unexpected result, column %0d sum %0d", column, sum));
            end
            else
            begin
                want = sums_q.pop_front();
                if (column !== want.col)
                    note_error($sformatf("column %0d, want %0d", column, want.col));
                if (sum !== want.total)
                    note_error($sformatf("column %0d sum %0d, want %0d",
                                         want.col, sum, want.total));
                if (row_done !== want.rdone)
                    note_error($sformatf("column %0d row_done %b, want %b",
                                         want.col, row_done, want.rdone));
                if (matrix_done !== want.mdone)
                    note_error($sformatf("column %0d matrix_done %b, want %b",
                                         want.col, matrix_done, want.mdone));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("matrix_multiply_accumulate_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short rows at the reset register values; load flags on loads are don't-care
        idle_pct = 0;
        for (int c = 0; c < MAX_COLS; c++)
            push_load(0, c, 16'sh8000, 1'b1, 1'b1);
        for (int c = 0; c < MAX_COLS; c++)
            push_load(1, c, 16'sh7FFF, 1'(c), !1'(c));
        for (int i = 0; i < 2; i++)
            push_feed(16'sh8000, i == 1, 1'b1);
        push_feed(16'sh0100, 1'b1, 1'b1);

        // Zero inner size with out_cols above the column count
        run_phase(0, 63, 83, 12);
        // Inner size above the store depth, no results emitted
        run_phase(127, 0, 0, 12);
        run_phase(1, 1, 33, 12);

        // Two elements past the inner size
        settle();
        set_reg(REG_INNER_SIZE, 2);
        set_reg(REG_OUT_COLS, 32);
        idle_pct = 0;
        for (int i = 0; i < 4; i++)
            push_feed((i % 2) ? 16'sh8000 : 16'sh7FFF, i == 3, 1'b0);
        random_phase(12);

        run_phase($urandom_range(2, 12), $urandom_range(1, 32), 83, 12);
        run_phase(3, 17, 33, 12);
        run_phase($urandom_range(0, 127), $urandom_range(0, 63), 0, 12);
        run_phase($urandom_range(1, 20), $urandom_range(1, 63), 83, 12);

        settle();
        if (errs == 0)
            $display("matrix_multiply_accumulate_core: match");
        else
            $display("matrix_multiply_accumulate_core: mismatch");
        $finish;
    end

endmodule
